// ===== sv/esd_pkg.sv =====
// esd_pkg: shared constants, types and character helpers of the escape sequence decoder
// no dependencies; imported by esd_result_if and every module of the block
`default_nettype none

package esd_pkg;

    // accumulator width of octal and hex runs (8 to 32)
    localparam int VALUE_WIDTH = 32;
    // width of the value field of a result word
    localparam int RESULT_W = 32;

    // decoder mode codes
    localparam logic [1:0] MODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_BACKSLASH = 2'd1;
    localparam logic [1:0] MODE_OCTAL     = 2'd2;
    localparam logic [1:0] MODE_HEX       = 2'd3;

    // result kind codes
    localparam logic [1:0] KIND_PLAIN  = 2'd0;
    localparam logic [1:0] KIND_ESCAPE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // characters with a role of their own
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_HEX_MARK  = 8'h78;

    // octal escape ends after this many digits
    localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]             mode;
        logic [VALUE_WIDTH-1:0] acc;
        logic [1:0]             digits;
    } esd_state_t;

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic [1:0]          kind;
        logic                run_last;
        logic                body_end;
    } esd_result_t;

    // up to two result words produced by one character
    typedef struct packed {
        logic [1:0]  count;
        esd_result_t res0;
        esd_result_t res1;
    } esd_push_t;

    function automatic logic octal_char(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // {valid, decoded value} of a single-character escape
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h27:   r = {1'b1, 8'h27};  // quote
            8'h22:   r = {1'b1, 8'h22};  // double quote
            8'h3F:   r = {1'b1, 8'h3F};  // question mark
            8'h5C:   r = {1'b1, 8'h5C};  // backslash
            8'h61:   r = {1'b1, 8'd7};   // a, bell
            8'h62:   r = {1'b1, 8'd8};   // b, backspace
            8'h66:   r = {1'b1, 8'd12};  // f, form feed
            8'h6E:   r = {1'b1, 8'd10};  // n, newline
            8'h72:   r = {1'b1, 8'd13};  // r, carriage return
            8'h74:   r = {1'b1, 8'd9};   // t, tab
            8'h76:   r = {1'b1, 8'd11};  // v, vertical tab
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic esd_result_t make_result(input logic [RESULT_W-1:0] v,
                                                input logic [1:0] k);
        esd_result_t r;
        r.value    = v;
        r.kind     = k;
        r.run_last = 1'b0;
        r.body_end = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/esd_char_if.sv =====
// esd_char_if: input channel of the escape sequence decoder, one raw character per word
// no dependencies
`default_nettype none

interface esd_char_if ();
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       text_end;

    modport source (output valid, output ch, output text_end, input ready);
    modport sink (input valid, input ch, input text_end, output ready);
endinterface

`default_nettype wire

// ===== sv/esd_result_if.sv =====
// esd_result_if: output channel of the escape sequence decoder, one decoded result per word
// depends on esd_pkg
`default_nettype none

interface esd_result_if import esd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] value;
    logic [1:0]          kind;
    logic                run_last;
    logic                body_end;

    modport source (output valid, output value, output kind, output run_last,
                    output body_end, input ready);
    modport sink (input valid, input value, input kind, input run_last,
                  input body_end, output ready);
endinterface

`default_nettype wire

// ===== sv/esd_decode.sv =====
// esd_decode: next-state and result logic for one character of a literal body
// depends on esd_pkg
`default_nettype none

module esd_decode import esd_pkg::*; (
    input  wire esd_state_t  state,
    input  wire logic [7:0]  ch,
    input  wire logic        text_end,
    output esd_state_t       state_next,
    output esd_push_t        push
);

    esd_result_t            res [2];
    logic [1:0]             n;
    esd_state_t             st;
    logic [VALUE_WIDTH-1:0] acc_oct;
    logic [VALUE_WIDTH-1:0] acc_hex;
    logic [4:0]             hexd;
    logic [8:0]             simple;

    always_comb
    begin
        st      = state;
        n       = 2'd0;
        res[0]  = make_result('0, KIND_PLAIN);
        res[1]  = make_result('0, KIND_PLAIN);
        hexd    = hex_value(ch);
        simple  = simple_escape(ch);
        acc_oct = {state.acc[VALUE_WIDTH-4:0], ch[2:0]};
        acc_hex = {state.acc[VALUE_WIDTH-5:0], hexd[3:0]};

        case (state.mode)
            MODE_IDLE:
            begin
                if (ch == CH_BACKSLASH) begin
                    if (text_end) begin
                        res[n[0]] = make_result(RESULT_W'(CH_BACKSLASH), KIND_ERROR);
                        n = n + 2'd1;
                    end
                    else begin
                        st.mode = MODE_BACKSLASH;
                    end
                end
                else begin
                    res[n[0]] = make_result(RESULT_W'(ch), KIND_PLAIN);
                    n = n + 2'd1;
                end
            end
            MODE_BACKSLASH:
            begin
                st.mode = MODE_IDLE;
                if (octal_char(ch)) begin
                    st.acc    = VALUE_WIDTH'(ch[2:0]);
                    st.digits = 2'd1;
                    st.mode   = MODE_OCTAL;
                end
                else if (ch == CH_HEX_MARK) begin
                    st.acc    = '0;
                    st.digits = 2'd0;
                    st.mode   = MODE_HEX;
                end
                else if (simple[8]) begin
                    res[n[0]] = make_result(RESULT_W'(simple[7:0]), KIND_ESCAPE);
                    n = n + 2'd1;
                end
                else begin
                    res[n[0]] = make_result(RESULT_W'(ch), KIND_ERROR);
                    n = n + 2'd1;
                end
            end
            MODE_OCTAL:
            begin
                if (octal_char(ch) && (state.digits < OCTAL_MAX_DIGITS)) begin
                    if (state.digits + 2'd1 >= OCTAL_MAX_DIGITS) begin
                        res[n[0]] = make_result(RESULT_W'(acc_oct), KIND_ESCAPE);
                        n = n + 2'd1;
                        st.mode   = MODE_IDLE;
                        st.acc    = '0;
                        st.digits = 2'd0;
                    end
                    else begin
                        st.acc    = acc_oct;
                        st.digits = state.digits + 2'd1;
                    end
                end
                else begin
                    res[n[0]] = make_result(RESULT_W'(state.acc), KIND_ESCAPE);
                    n = n + 2'd1;
                    st.mode   = MODE_IDLE;
                    st.acc    = '0;
                    st.digits = 2'd0;
                    // the terminating character is then taken as a fresh one
                    if (ch == CH_BACKSLASH) begin
                        if (text_end) begin
                            res[n[0]] = make_result(RESULT_W'(CH_BACKSLASH), KIND_ERROR);
                            n = n + 2'd1;
                        end
                        else begin
                            st.mode = MODE_BACKSLASH;
                        end
                    end
                    else begin
                        res[n[0]] = make_result(RESULT_W'(ch), KIND_PLAIN);
                        n = n + 2'd1;
                    end
                end
            end
            default:
            begin
                // hex run
                if (hexd[4]) begin
                    st.acc = acc_hex;
                end
                else begin
                    res[n[0]] = make_result(RESULT_W'(state.acc), KIND_ESCAPE);
                    n = n + 2'd1;
                    st.mode   = MODE_IDLE;
                    st.acc    = '0;
                    st.digits = 2'd0;
                    if (ch == CH_BACKSLASH) begin
                        if (text_end) begin
                            res[n[0]] = make_result(RESULT_W'(CH_BACKSLASH), KIND_ERROR);
                            n = n + 2'd1;
                        end
                        else begin
                            st.mode = MODE_BACKSLASH;
                        end
                    end
                    else begin
                        res[n[0]] = make_result(RESULT_W'(ch), KIND_PLAIN);
                        n = n + 2'd1;
                    end
                end
            end
        endcase

        // close whatever is still open at the end of the body
        if (text_end) begin
            if ((st.mode == MODE_OCTAL) || (st.mode == MODE_HEX)) begin
                res[n[0]] = make_result(RESULT_W'(st.acc), KIND_ESCAPE);
                n = n + 2'd1;
            end
            else if (st.mode == MODE_BACKSLASH) begin
                res[n[0]] = make_result(RESULT_W'(CH_BACKSLASH), KIND_ERROR);
                n = n + 2'd1;
            end
            st.mode   = MODE_IDLE;
            st.acc    = '0;
            st.digits = 2'd0;
        end

        if (n == 2'd1) begin
            res[0].run_last = 1'b1;
            res[0].body_end = text_end;
        end
        else if (n == 2'd2) begin
            res[1].run_last = 1'b1;
            res[1].body_end = text_end;
        end
    end

    assign state_next = st;
    assign push.count = n;
    assign push.res0  = res[0];
    assign push.res1  = res[1];

endmodule

`default_nettype wire

// ===== sv/esd_result_fifo.sv =====
// esd_result_fifo: small result queue taking up to two words per cycle, giving one
// while result_out is ready; depends on esd_pkg and esd_result_if
`default_nettype none

module esd_result_fifo import esd_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire esd_push_t   push,
    output logic             room,
    esd_result_if.source     result_out
);

    esd_result_t           mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_p1;

    assign pop       = result_out.valid && result_out.ready;
    assign wr_ptr_p1 = wr_ptr_reg + FIFO_PTR_W'(1);
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_p1] <= push.res1;
        end
    end

    assign result_out.valid    = (count_reg != '0);
    assign result_out.value    = mem[rd_ptr_reg].value;
    assign result_out.kind     = mem[rd_ptr_reg].kind;
    assign result_out.run_last = mem[rd_ptr_reg].run_last;
    assign result_out.body_end = mem[rd_ptr_reg].body_end;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("result words pushed without room");

endmodule

`default_nettype wire

// ===== sv/escape_sequence_decoder_core.sv =====
// escape_sequence_decoder_core: top level of the escape sequence decoder
// depends on esd_pkg, esd_char_if, esd_result_if, esd_decode, esd_result_fifo
//
//  channel     | dir | word                               | handshake
//  ------------+-----+------------------------------------+-------------------
//  char_in     | in  | ch[7:0], text_end                  | valid/ready
//  result_out  | out | value[31:0], kind[1:0], run_last,  | valid/ready
//              |     | body_end                           |
//
// a character taken at one edge is decoded from the input register in the next cycle;
// its 0 to 2 result words enter a four-word queue at an edge where the queue has room,
// and are offered on result_out from the queue in order after that edge
// one character per cycle is taken while the queue has room for two words; the queue
// drains one word per cycle while result_out is ready, so a stream of two-result
// characters runs at half rate; reset empties the input register and queue; a stalled
// result_out fills the queue, which then holds char_in off
`default_nettype none

module escape_sequence_decoder_core import esd_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    esd_char_if.sink       char_in,
    esd_result_if.source   result_out
);

    // input register
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] ch_reg;
    logic       te_reg;

    // decoder state
    esd_state_t state_reg;
    esd_state_t state_next;

    esd_push_t  dec_push;
    esd_push_t  push;
    logic       room;
    logic       advance;
    logic       take;

    // decode the registered character against the current state
    esd_decode u_decode (
        .state      (state_reg),
        .ch         (ch_reg),
        .text_end   (te_reg),
        .state_next (state_next),
        .push       (dec_push)
    );

    // the registered character is consumed once the queue can take two words
    assign advance = in_vld_reg && room;
    assign take    = char_in.valid && char_in.ready;

    // ready looks only at the input register and queue room, not at any state
    assign char_in.ready = !in_vld_reg || advance;

    always_comb
    begin
        push       = dec_push;
        push.count = advance ? dec_push.count : 2'd0;
        in_vld_next = take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg       <= 1'b0;
            state_reg.mode   <= MODE_IDLE;
            state_reg.acc    <= '0;
            state_reg.digits <= 2'd0;
        end
        else begin
            in_vld_reg <= in_vld_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // input payload, loaded on acceptance
    always_ff @(posedge clk)
    begin
        if (take) begin
            ch_reg <= char_in.ch;
            te_reg <= char_in.text_end;
        end
    end

    // result queue
    esd_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .result_out (result_out)
    );

    // the end of a body always yields at least one word
    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && te_reg) |-> (dec_push.count != 2'd0))
        else $error("text end produced no result word");

    // the end of a body leaves the decoder idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && te_reg) |=> (state_reg.mode == MODE_IDLE))
        else $error("decoder not idle after text end");

    // an open octal run holds one or two digits
    a_octal_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_OCTAL) |->
            ((state_reg.digits == 2'd1) || (state_reg.digits == 2'd2)))
        else $error("octal digit count out of range");

    // at most two words per character
    a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dec_push.count != 2'd3)
        else $error("more than two result words for one character");

endmodule

`default_nettype wire
